FILE: hdl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion macros for the compass heading RTL; empty for synthesis.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// property checked at every clock edge outside reset
`define CHA_ASSERT(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error(msg);

// consequent checked in the cycle after the antecedent
`define CHA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`else

`define CHA_ASSERT(label, clk, rst_n, prop, msg)
`define CHA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)

`endif

`endif

FILE: hdl/cha_pkg.sv
// ----------------------------------------------------------------------------
// cha_pkg
// Types, constants and the arctangent table of the compass heading block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package cha_pkg;

	// corrected axis width and CORDIC working format
	localparam int CORR_W     = 14;
	localparam int FRAC_SHIFT = 20;
	localparam int WORK_W     = 37;
	localparam int Z_W        = 32;
	localparam int ADDR_W     = 4;
	localparam int DATA_W     = 32;

	// register field widths
	localparam int XOFF_W = 12;
	localparam int YOFF_W = 12;
	localparam int DECL_W = 14;

	// binary angle of +90 and -90 degrees
	localparam logic [Z_W-1:0] Z_POS_QUARTER = 32'h4000_0000;
	localparam logic [Z_W-1:0] Z_NEG_QUARTER = 32'hC000_0000;

	// register index on the configuration port
	typedef enum logic [1:0] {
		REG_X_OFFSET    = 2'd0,
		REG_Y_OFFSET    = 2'd1,
		REG_DECLINATION = 2'd2
	} cha_reg_e_t;

	// configuration register contents
	typedef struct packed {
		logic signed [XOFF_W-1:0] x_offset;
		logic signed [YOFF_W-1:0] y_offset;
		logic signed [DECL_W-1:0] declination;
	} cha_cfg_t;

	// vector handed from cell to cell
	typedef struct packed {
		logic                     zero;
		logic signed [WORK_W-1:0] x;
		logic signed [WORK_W-1:0] y;
		logic        [Z_W-1:0]    z;
	} cha_stage_t;

	// atan(2^-i) in units of 2^-32 turn
	function automatic logic [Z_W-1:0] atan_turn(input int idx);
		logic [Z_W-1:0] v;
		case (idx)
			0:  v = 32'h2000_0000;
			1:  v = 32'h12E4_051E;
			2:  v = 32'h09FB_385B;
			3:  v = 32'h0511_11D4;
			4:  v = 32'h028B_0D43;
			5:  v = 32'h0145_D7E1;
			6:  v = 32'h00A2_F61E;
			7:  v = 32'h0051_7C55;
			8:  v = 32'h0028_BE53;
			9:  v = 32'h0014_5F2F;
			10: v = 32'h000A_2F98;
			11: v = 32'h0005_17CC;
			12: v = 32'h0002_8BE6;
			13: v = 32'h0001_45F3;
			14: v = 32'h0000_A2FA;
			15: v = 32'h0000_517D;
			16: v = 32'h0000_28BE;
			17: v = 32'h0000_145F;
			18: v = 32'h0000_0A2F;
			19: v = 32'h0000_0517;
			20: v = 32'h0000_028B;
			21: v = 32'h0000_0145;
			22: v = 32'h0000_00A2;
			23: v = 32'h0000_0051;
			default: v = '0;
		endcase
		return v;
	endfunction

	// signed width of heading arithmetic for a given angle format
	function automatic int heading_w(input int frac);
		int w;
		w = $clog2(360 * (2 ** frac)) + 3;
		return (w < 17) ? 17 : w;
	endfunction

endpackage

FILE: hdl/cha_regs.sv
// ----------------------------------------------------------------------------
// cha_regs
// APB-style register file: hard-iron offsets and magnetic declination.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module cha_regs (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [cha_pkg::ADDR_W-1:0]  paddr,
	input  logic [cha_pkg::DATA_W-1:0]  pwdata,
	output logic [cha_pkg::DATA_W-1:0]  prdata,
	output logic                        pready,
	output cha_pkg::cha_cfg_t           cfg
);

	cha_pkg::cha_cfg_t  cfg_q;
	cha_pkg::cha_reg_e_t reg_sel;
	logic               wr_en;

	assign pready  = 1'b1;
	assign reg_sel = cha_pkg::cha_reg_e_t'(paddr[3:2]);
	assign wr_en   = psel && penable && pwrite;
	assign cfg     = cfg_q;

	// register writes, low field bits kept
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.x_offset    <= 12'sd10;
			cfg_q.y_offset    <= -12'sd182;
			cfg_q.declination <= '0;
		end else if (wr_en) begin
			case (reg_sel)
				cha_pkg::REG_X_OFFSET:    cfg_q.x_offset    <= pwdata[cha_pkg::XOFF_W-1:0];
				cha_pkg::REG_Y_OFFSET:    cfg_q.y_offset    <= pwdata[cha_pkg::YOFF_W-1:0];
				cha_pkg::REG_DECLINATION: cfg_q.declination <= pwdata[cha_pkg::DECL_W-1:0];
				default: ;
			endcase
		end
	end

	// read mux, values sign extended
	always_comb begin
		case (reg_sel)
			cha_pkg::REG_X_OFFSET:
				prdata = {{(cha_pkg::DATA_W-cha_pkg::XOFF_W){cfg_q.x_offset[cha_pkg::XOFF_W-1]}},
					cfg_q.x_offset};
			cha_pkg::REG_Y_OFFSET:
				prdata = {{(cha_pkg::DATA_W-cha_pkg::YOFF_W){cfg_q.y_offset[cha_pkg::YOFF_W-1]}},
					cfg_q.y_offset};
			cha_pkg::REG_DECLINATION:
				prdata = {{(cha_pkg::DATA_W-cha_pkg::DECL_W){
					cfg_q.declination[cha_pkg::DECL_W-1]}}, cfg_q.declination};
			default:
				prdata = '0;
		endcase
	end

endmodule

FILE: hdl/cha_cordic_cell.sv
// ----------------------------------------------------------------------------
// cha_cordic_cell
// One vectoring CORDIC iteration with its own pipeline register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module cha_cordic_cell #(
	parameter int SHIFT = 0
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	input  cha_pkg::cha_stage_t vec_in,
	input  logic                en_next,
	output logic                en,
	output logic                out_valid,
	output cha_pkg::cha_stage_t vec_out
);

	localparam logic [cha_pkg::Z_W-1:0] ATAN = cha_pkg::atan_turn(SHIFT);

	logic                                valid_q;
	cha_pkg::cha_stage_t                 vec_s1;
	cha_pkg::cha_stage_t                 vec_nx;
	logic signed [cha_pkg::WORK_W-1:0]   dx;
	logic signed [cha_pkg::WORK_W-1:0]   dy;

	// load when empty or when the neighbor takes the held vector
	assign en        = !valid_q || en_next;
	assign out_valid = valid_q;
	assign vec_out   = vec_s1;

	// rotate toward the x axis
	always_comb begin
		dx          = vec_in.y >>> SHIFT;
		dy          = vec_in.x >>> SHIFT;
		vec_nx.zero = vec_in.zero;
		if (!vec_in.y[cha_pkg::WORK_W-1]) begin
			vec_nx.x = vec_in.x + dx;
			vec_nx.y = vec_in.y - dy;
			vec_nx.z = vec_in.z + ATAN;
		end else begin
			vec_nx.x = vec_in.x - dx;
			vec_nx.y = vec_in.y + dy;
			vec_nx.z = vec_in.z - ATAN;
		end
	end

	// stage valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (en) begin
			valid_q <= in_valid;
		end
	end

	// stage payload
	always_ff @(posedge clk) begin
		if (en && in_valid) begin
			vec_s1 <= vec_nx;
		end
	end

endmodule

FILE: hdl/cha_angle_post.sv
// ----------------------------------------------------------------------------
// cha_angle_post
// Binary angle to signed angle in fractional degrees, rounded half away from zero.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module cha_angle_post #(
	parameter int ANGLE_FRAC_BITS = 6
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	input  cha_pkg::cha_stage_t vec_in,
	input  logic                en_next,
	output logic                en,
	output logic                out_valid,
	output logic signed [cha_pkg::heading_w(ANGLE_FRAC_BITS)-1:0] angle
);

	localparam int FULL   = 360 * (2 ** ANGLE_FRAC_BITS);
	localparam int FULL_W = $clog2(FULL + 1);
	localparam int PROD_W = cha_pkg::Z_W + FULL_W;
	localparam int H_W    = cha_pkg::heading_w(ANGLE_FRAC_BITS);
	localparam int ZW     = cha_pkg::Z_W;

	logic                     v_s1, v_s2, v_s3;
	logic                     en1, en2, en3;
	logic                     neg_s1, neg_s2;
	logic [ZW-1:0]            mag_s1;
	logic [PROD_W-1:0]        prod_s2;
	logic signed [H_W-1:0]    angle_s3;
	logic [ZW-1:0]            mag_nx;
	logic [PROD_W-1:0]        rnd;
	logic signed [H_W-1:0]    r_ext;

	// stage enables, last one follows the consumer
	assign en3       = !v_s3 || en_next;
	assign en2       = !v_s2 || en3;
	assign en1       = !v_s1 || en2;
	assign en        = en1;
	assign out_valid = v_s3;
	assign angle     = angle_s3;

	// magnitude of the signed binary angle, forced to zero for a null vector
	always_comb begin
		if (vec_in.zero) begin
			mag_nx = '0;
		end else if (vec_in.z[ZW-1]) begin
			mag_nx = ~vec_in.z + ZW'(1);
		end else begin
			mag_nx = vec_in.z;
		end
	end

	// round and restore sign
	always_comb begin
		rnd   = prod_s2 + (PROD_W'(1) << (ZW - 1));
		r_ext = H_W'(rnd[PROD_W-1:ZW]);
	end

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (en1) v_s1 <= in_valid;
			if (en2) v_s2 <= v_s1;
			if (en3) v_s3 <= v_s2;
		end
	end

	// payload stages
	always_ff @(posedge clk) begin
		if (en1 && in_valid) begin
			mag_s1 <= mag_nx;
			neg_s1 <= !vec_in.zero && vec_in.z[ZW-1];
		end
		if (en2 && v_s1) begin
			prod_s2 <= PROD_W'(mag_s1) * PROD_W'(FULL);
			neg_s2  <= neg_s1;
		end
		if (en3 && v_s2) begin
			angle_s3 <= neg_s2 ? -r_ext : r_ext;
		end
	end

endmodule

FILE: hdl/compass_heading_atan2.sv
// ----------------------------------------------------------------------------
// compass_heading_atan2
// Compass heading from one magnetometer X/Y sample via a pipelined CORDIC.
// ----------------------------------------------------------------------------
// The block takes one X/Y sample per clock unless sample_stall is high and
// returns one heading per sample, in order, in units of 2^-ANGLE_FRAC_BITS
// degree. Each sample passes a correction stage, one CORDIC cell per iteration
// (CORDIC_STAGES cells), three conversion stages and the output register.
// Throughput is one transfer per cycle without stalls, set by the row of
// CORDIC cells each holding one vector; a stall on the heading side backs up
// stage by stage, so bubbles in the pipeline are filled before the sample side
// is stalled. Registers: offset X at 0x0, offset Y at 0x4, declination at 0x8.
`timescale 1ns / 1ps

module compass_heading_atan2 #(
	parameter int ANGLE_FRAC_BITS = 6,
	parameter int CORDIC_STAGES   = 16
) (
	input  logic                        clk,
	input  logic                        arst_n,
	// sample channel
	input  logic                        sample_valid,
	output logic                        sample_stall,
	input  logic signed [12:0]          x_field,
	input  logic signed [12:0]          y_field,
	// heading channel
	output logic                        heading_valid,
	input  logic                        heading_stall,
	output logic [14:0]                 heading,
	// configuration port
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [cha_pkg::ADDR_W-1:0]  paddr,
	input  logic [cha_pkg::DATA_W-1:0]  pwdata,
	output logic [cha_pkg::DATA_W-1:0]  prdata,
	output logic                        pready
);

	`include "assert_macros.svh"

	localparam int FULL    = 360 * (2 ** ANGLE_FRAC_BITS);
	localparam int QUARTER = 90 * (2 ** ANGLE_FRAC_BITS);
	localparam int H_W     = cha_pkg::heading_w(ANGLE_FRAC_BITS);
	localparam int CW      = cha_pkg::CORR_W;
	localparam int WW      = cha_pkg::WORK_W;
	localparam int FS      = cha_pkg::FRAC_SHIFT;
	localparam logic signed [H_W-1:0] FULL_H    = H_W'(FULL);
	localparam logic signed [H_W-1:0] QUARTER_H = H_W'(QUARTER);

	cha_pkg::cha_cfg_t          cfg;
	logic                       v_s1;
	logic                       en_s1;
	logic signed [CW-1:0]       xc_s1, yc_s1;
	logic signed [CW-1:0]       xc_nx, yc_nx;
	logic signed [WW-1:0]       xw, yw;
	cha_pkg::cha_stage_t        rot_vec;
	cha_pkg::cha_stage_t        link [0:CORDIC_STAGES];
	logic [CORDIC_STAGES:0]     link_v;
	logic [CORDIC_STAGES:0]     link_en;
	logic                       post_v;
	logic signed [H_W-1:0]      angle;
	logic                       en_out;
	logic                       out_valid_q;
	logic [H_W-1:0]             out_h_q;
	logic signed [H_W-1:0]      h0, h1, h2, decl_ext;

	// configuration registers
	cha_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// hard-iron correction
	assign xc_nx = {x_field[12], x_field}
		- {{(CW-cha_pkg::XOFF_W){cfg.x_offset[cha_pkg::XOFF_W-1]}}, cfg.x_offset};
	assign yc_nx = {y_field[12], y_field}
		- {{(CW-cha_pkg::YOFF_W){cfg.y_offset[cha_pkg::YOFF_W-1]}}, cfg.y_offset};

	assign en_s1        = !v_s1 || link_en[0];
	assign sample_stall = !en_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en_s1) begin
			v_s1 <= sample_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s1 && sample_valid) begin
			xc_s1 <= xc_nx;
			yc_s1 <= yc_nx;
		end
	end

	// scale to working format and pre-rotate the left half plane by 90 degrees
	assign xw = {{(WW-CW-FS){xc_s1[CW-1]}}, xc_s1, {FS{1'b0}}};
	assign yw = {{(WW-CW-FS){yc_s1[CW-1]}}, yc_s1, {FS{1'b0}}};

	always_comb begin
		rot_vec.zero = (xc_s1 == '0) && (yc_s1 == '0);
		if (!xc_s1[CW-1]) begin
			rot_vec.x = xw;
			rot_vec.y = yw;
			rot_vec.z = '0;
		end else if (!yc_s1[CW-1]) begin
			rot_vec.x = yw;
			rot_vec.y = -xw;
			rot_vec.z = cha_pkg::Z_POS_QUARTER;
		end else begin
			rot_vec.x = -yw;
			rot_vec.y = xw;
			rot_vec.z = cha_pkg::Z_NEG_QUARTER;
		end
	end
	assign link[0]   = rot_vec;
	assign link_v[0] = v_s1;

	// row of CORDIC cells
	for (genvar k = 0; k < CORDIC_STAGES; k++) begin : g_cell
		cha_cordic_cell #(
			.SHIFT (k)
		) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.in_valid  (link_v[k]),
			.vec_in    (link[k]),
			.en_next   (link_en[k+1]),
			.en        (link_en[k]),
			.out_valid (link_v[k+1]),
			.vec_out   (link[k+1])
		);
	end

	// binary angle to fractional degrees
	cha_angle_post #(
		.ANGLE_FRAC_BITS (ANGLE_FRAC_BITS)
	) u_post (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (link_v[CORDIC_STAGES]),
		.vec_in    (link[CORDIC_STAGES]),
		.en_next   (en_out),
		.en        (link_en[CORDIC_STAGES]),
		.out_valid (post_v),
		.angle     (angle)
	);

	// quarter turn, declination, single wrap and saturation
	always_comb begin
		decl_ext = {{(H_W-cha_pkg::DECL_W){cfg.declination[cha_pkg::DECL_W-1]}},
			cfg.declination};
		h0 = angle - QUARTER_H + decl_ext;
		if (h0 < 0) begin
			h1 = h0 + FULL_H;
		end else if (h0 > FULL_H) begin
			h1 = h0 - FULL_H;
		end else begin
			h1 = h0;
		end
		if (h1 < 0) begin
			h2 = '0;
		end else if (h1 > FULL_H) begin
			h2 = FULL_H;
		end else begin
			h2 = h1;
		end
	end

	// output register
	assign en_out = !out_valid_q || !heading_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (en_out) begin
			out_valid_q <= post_v;
		end
	end

	always_ff @(posedge clk) begin
		if (en_out && post_v) begin
			out_h_q <= h2;
		end
	end

	assign heading_valid = out_valid_q;
	assign heading       = out_h_q[14:0];

	// checks
	`CHA_ASSERT(a_heading_range, clk, arst_n, out_valid_q |-> (!out_h_q[H_W-1] && (out_h_q <= FULL_H)), "heading outside 0..360 degrees")
	`CHA_ASSERT(a_stall_full, clk, arst_n, sample_stall |-> (heading_valid && heading_stall), "sample stalled while the pipeline can move")
	`CHA_ASSERT(a_cordic_x_pos, clk, arst_n, (link_v[CORDIC_STAGES] && !link[CORDIC_STAGES].zero) |-> !link[CORDIC_STAGES].x[WW-1], "CORDIC x went negative")
	`CHA_ASSERT_NEXT(a_post_to_out, clk, arst_n, post_v && en_out, heading_valid, "converted angle lost before the output register")

endmodule

FILE: tb/tb_compass_heading_atan2.sv
// ----------------------------------------------------------------------------
// tb_compass_heading_atan2
// Self-checking bench for the compass heading block. A driver feeds X/Y
// samples from a queue and a monitor checks each heading against a bit-exact
// CORDIC predictor. Offsets and declination change over the run through the
// configuration port, including junk upper bits and a write to a spare index.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_compass_heading_atan2;

	localparam int FRAC_BITS   = 6;
	localparam int STAGES      = 16;
	localparam int TURN_TABLE  = 24;
	localparam int LATENCY     = STAGES + 5;
	localparam int FULL_TURN   = 360 * (2 ** FRAC_BITS);
	localparam int QUARTER     = 90 * (2 ** FRAC_BITS);
	localparam logic [1:0] REG_SPARE = 2'd3;
	localparam logic [31:0] TURN_POS_90 = 32'h4000_0000;
	localparam logic [31:0] TURN_NEG_90 = 32'hC000_0000;

	// atan(2^-i) in 2^-32 turn
	localparam logic [31:0] ATAN_TURNS [0:23] = '{
		32'h2000_0000, 32'h12E4_051E, 32'h09FB_385B, 32'h0511_11D4,
		32'h028B_0D43, 32'h0145_D7E1, 32'h00A2_F61E, 32'h0051_7C55,
		32'h0028_BE53, 32'h0014_5F2F, 32'h000A_2F98, 32'h0005_17CC,
		32'h0002_8BE6, 32'h0001_45F3, 32'h0000_A2FA, 32'h0000_517D,
		32'h0000_28BE, 32'h0000_145F, 32'h0000_0A2F, 32'h0000_0517,
		32'h0000_028B, 32'h0000_0145, 32'h0000_00A2, 32'h0000_0051
	};

	typedef struct {
		logic signed [12:0] x;
		logic signed [12:0] y;
	} sample_t;

	logic                        clk = 1'b0;
	logic                        arst_n;
	logic                        sample_valid;
	logic                        sample_stall;
	logic signed [12:0]          x_field;
	logic signed [12:0]          y_field;
	logic                        heading_valid;
	logic                        heading_stall;
	logic [14:0]                 heading;
	logic                        psel;
	logic                        penable;
	logic                        pwrite;
	logic [cha_pkg::ADDR_W-1:0]  paddr;
	logic [cha_pkg::DATA_W-1:0]  pwdata;
	logic [cha_pkg::DATA_W-1:0]  prdata;
	logic                        pready;

	// calibration as the block should hold it
	logic signed [11:0] cal_x_offset;
	logic signed [11:0] cal_y_offset;
	logic signed [13:0] cal_declination;

	sample_t     pending_samples[$];
	logic [14:0] expected_headings[$];
	sample_t     next_sample;
	int          sender_gap_pct;
	int          sink_stall_pct;
	int          mismatches;
	logic [14:0] want_heading;

	compass_heading_atan2 #(
		.ANGLE_FRAC_BITS(FRAC_BITS),
		.CORDIC_STAGES  (STAGES)
	) uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.sample_valid (sample_valid),
		.sample_stall (sample_stall),
		.x_field      (x_field),
		.y_field      (y_field),
		.heading_valid(heading_valid),
		.heading_stall(heading_stall),
		.heading      (heading),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready)
	);

	always #5 clk = ~clk;

	// heading of one sample under the current calibration
	function automatic logic [14:0] predict_heading(logic signed [12:0] xs,
			logic signed [12:0] ys);
		longint xc, yc, vx, vy, dx, dy, swap, angle, h;
		longint unsigned mag;
		logic [31:0] z;
		int zs;
		xc = longint'(xs) - longint'(cal_x_offset);
		yc = longint'(ys) - longint'(cal_y_offset);
		angle = 0;
		if (xc != 0 || yc != 0) begin
			vx = xc * 64'sd1048576;
			vy = yc * 64'sd1048576;
			z = '0;
			// left half plane: pre-rotate by a quarter turn
			if (vx < 0) begin
				swap = vx;
				if (vy >= 0) begin
					vx = vy;
					vy = -swap;
					z = TURN_POS_90;
				end else begin
					vx = -vy;
					vy = swap;
					z = TURN_NEG_90;
				end
			end
			// vectoring iterations with floor shifts
			for (int s = 0; s < STAGES && s < TURN_TABLE; s++) begin
				dx = vy >>> s;
				dy = vx >>> s;
				if (vy >= 0) begin
					vx = vx + dx;
					vy = vy - dy;
					z = z + ATAN_TURNS[s];
				end else begin
					vx = vx - dx;
					vy = vy + dy;
					z = z - ATAN_TURNS[s];
				end
			end
			// binary angle to degree steps, magnitude rounded half away from zero
			zs = $signed(z);
			mag = (zs < 0) ? -longint'(zs) : longint'(zs);
			mag = (mag * 64'(FULL_TURN) + 64'h8000_0000) >> 32;
			angle = (zs < 0) ? -longint'(mag) : longint'(mag);
		end
		h = angle - QUARTER + longint'(cal_declination);
		if (h < 0)
			h = h + FULL_TURN;
		else if (h > FULL_TURN)
			h = h - FULL_TURN;
		if (h < 0)
			h = 0;
		if (h > FULL_TURN)
			h = FULL_TURN;
		return h[14:0];
	endfunction

	// driver: loads the next sample once the current transfer is done
	always @(posedge clk) begin
		if (!arst_n) begin
			sample_valid <= 1'b0;
		end else if (!sample_valid || !sample_stall) begin
			if (pending_samples.size() != 0 && $urandom_range(99) >= sender_gap_pct) begin
				next_sample = pending_samples.pop_front();
				// config is steady while items are in flight, so predict now
				expected_headings.push_back(predict_heading(next_sample.x, next_sample.y));
				sample_valid <= 1'b1;
				x_field <= next_sample.x;
				y_field <= next_sample.y;
			end else begin
				sample_valid <= 1'b0;
			end
		end
	end

	// monitor: checks each heading transfer and draws the next stall
	always @(posedge clk) begin
		if (!arst_n) begin
			heading_stall <= 1'b0;
		end else begin
			if (heading_valid && !heading_stall) begin
				if (expected_headings.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("heading %0d arrived with nothing outstanding", heading);
				end else begin
					want_heading = expected_headings.pop_front();
					if (heading !== want_heading) begin
						mismatches++;
						if (mismatches <= 10)
							$display("heading mismatch: expected %0d, got %0d",
								want_heading, heading);
					end
				end
			end
			heading_stall <= ($urandom_range(99) < sink_stall_pct);
		end
	end

	// one register write: setup cycle, then access cycle
	task automatic write_reg(logic [1:0] idx, logic [31:0] value);
		@(posedge clk);
		psel    <= 1'b1;
		pwrite  <= 1'b1;
		penable <= 1'b0;
		paddr   <= {idx, 2'b00};
		pwdata  <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		case (idx)
			cha_pkg::REG_X_OFFSET:    cal_x_offset = value[11:0];
			cha_pkg::REG_Y_OFFSET:    cal_y_offset = value[11:0];
			cha_pkg::REG_DECLINATION: cal_declination = value[13:0];
			default: ;
		endcase
	endtask

	// upper bits carry junk, only the field width must be kept
	task automatic set_calibration(logic [11:0] xo, logic [11:0] yo, logic [13:0] dc);
		logic [31:0] junk;
		junk = $urandom;
		write_reg(cha_pkg::REG_X_OFFSET, {junk[31:12], xo});
		junk = $urandom;
		write_reg(cha_pkg::REG_Y_OFFSET, {junk[31:12], yo});
		junk = $urandom;
		write_reg(cha_pkg::REG_DECLINATION, {junk[31:14], dc});
	endtask

	task automatic add_sample(int x, int y);
		sample_t s;
		s.x = 13'(x);
		s.y = 13'(y);
		pending_samples.push_back(s);
	endtask

	// random samples: mostly full range, some near the offset point or on an axis
	task automatic add_random_samples(int count);
		int pick;
		int x;
		int y;
		for (int k = 0; k < count; k++) begin
			pick = $urandom_range(99);
			x = $urandom;
			y = $urandom;
			if (pick >= 90) begin
				if (pick[0])
					x = int'(cal_x_offset);
				else
					y = int'(cal_y_offset);
			end else if (pick >= 70) begin
				x = int'(cal_x_offset) + int'($urandom_range(6)) - 3;
				y = int'(cal_y_offset) + int'($urandom_range(6)) - 3;
			end
			add_sample(x, y);
		end
	endtask

	// block until every queued sample is through and checked
	task automatic wait_drained();
		@(negedge clk);
		while (pending_samples.size() != 0 || sample_valid || expected_headings.size() != 0)
			@(negedge clk);
	endtask

	initial begin
		arst_n          = 1'b0;
		sample_valid    = 1'b0;
		x_field         = '0;
		y_field         = '0;
		heading_stall   = 1'b0;
		psel            = 1'b0;
		penable         = 1'b0;
		pwrite          = 1'b0;
		paddr           = '0;
		pwdata          = '0;
		mismatches      = 0;
		cal_x_offset    = 12'sd10;
		cal_y_offset    = -12'sd182;
		cal_declination = '0;
		sender_gap_pct  = 20;
		sink_stall_pct  = 53;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed samples under reset calibration (offsets 10 / -182)
		add_sample(-4096, -4096);
		add_sample(4095, 4095);
		add_sample(-4096, 4095);
		add_sample(4095, -4096);
		add_sample(10, -182);
		add_sample(0, 0);
		add_sample(-100, -182);
		add_sample(-100, -183);
		add_sample(-100, 0);
		add_sample(100, -182);
		add_sample(10, 0);
		add_sample(10, -300);
		add_sample(11, -182);
		add_sample(10, -181);
		add_sample(9, -182);
		add_sample(9, -183);
		add_sample(4095, -182);
		add_sample(-4096, -182);
		add_sample(10, 4095);
		add_sample(10, -4096);
		add_sample(-1, -1);
		add_sample(2730, -2731);
		add_random_samples(80);
		wait_drained();

		// offset extremes and declination at plus or minus 90 degrees
		set_calibration(-12'sd2048, 12'sd2047, -14'sd5760);
		add_random_samples(107);
		wait_drained();
		set_calibration(12'sd2047, -12'sd2048, 14'sd5760);
		add_random_samples(107);
		wait_drained();

		// sender slow, receiver mostly ready
		sender_gap_pct = 53;
		sink_stall_pct = 20;
		// declination far below a quarter turn forces the low clamp
		set_calibration('0, '0, 14'h2000);
		add_random_samples(107);
		wait_drained();
		set_calibration(12'($urandom), 12'($urandom), 14'sd8191);
		// spare index must not disturb any register
		write_reg(REG_SPARE, $urandom);
		add_random_samples(107);
		wait_drained();
		set_calibration(12'($urandom), 12'($urandom), 14'($urandom_range(11520) - 5760));
		add_random_samples(107);
		wait_drained();

		// full rate on both sides
		sender_gap_pct = 0;
		sink_stall_pct = 0;
		set_calibration('0, '0, '0);
		add_random_samples(107);
		wait_drained();
		set_calibration(12'($urandom), 12'($urandom), 14'($urandom));
		add_random_samples(107);
		wait_drained();

		// quiet window to catch stray results
		repeat (LATENCY + 8) @(posedge clk);
		if (mismatches == 0 && expected_headings.size() == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

	// watchdog
	initial begin
		#5000000;
		$display("FAILED: results differ");
		$finish;
	end

endmodule
